/* src/emgrms_pkg.sv */
// ----------------------------------------------------------------------------
// EMG window RMS alert package
// Widths, register indexes and reset values shared by the block and its
// checker.
// ----------------------------------------------------------------------------
package emgrms_pkg;

   localparam int SAMPLE_W  = 12;
   localparam int RUN_W     = 16;
   localparam int RUNS_W    = 8;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 12;
   localparam int REQ_DAT_W = 16;
   localparam int RSP_DAT_W = 32;

   localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] REG_BIAS_LEVEL      = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ALERT_THRESHOLD = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RUNS_TO_ALERT   = 8'd2;

   localparam logic [SAMPLE_W-1:0] BIAS_RESET      = 12'd2048;
   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'd500;
   localparam logic [RUNS_W-1:0]   RUNS_RESET      = 8'd5;

   // Bit positions of the result fields inside rsp_tdata.
   localparam int RSP_RUN_LSB   = SAMPLE_W;
   localparam int RSP_ALERT_BIT = SAMPLE_W + RUN_W;

endpackage

/* src/emg_window_rms_alert_top.sv */
// ----------------------------------------------------------------------------
// EMG window RMS alert
// Sliding-window RMS of rectified converter samples with a run counter and a
// sticky over-level alert.
// ----------------------------------------------------------------------------
// Each request carries one 12-bit sample. It is rectified around bias_level,
// stored in a WINDOW_LEN-entry circular memory, and its square is added to an
// exact running sum (the oldest square leaves once the window is full). The
// first WINDOW_LEN requests after reset give no response; every later request
// gives one response with floor(sqrt(sum / WINDOW_LEN)), the run of results at
// or above alert_threshold, and the sticky alert. A request is accepted in the
// idle state and then passes through the memory read, the removal and the
// addition of a square through the shared 12x12 multiplier, the bit-serial
// square root (one result bit per cycle, testing r*r*WINDOW_LEN against the
// sum, so no divider is needed) and the forming of the response, after which
// req_tready returns. While the window fills, no square root runs and the
// request returns to idle after the addition. A response that has not been
// taken holds the block in its output state. The window memory needs no
// clearing pass after reset. Configuration writes are always ready and are
// meant for idle periods.
module emg_window_rms_alert_top #(
   parameter int WINDOW_LEN = 128
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request stream; req_tdata: [11:0] raw_sample, [15:12] zero.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [emgrms_pkg::REQ_DAT_W-1:0]     req_tdata,
   // Response stream; rsp_tdata: [11:0] rms_level, [27:12] over_run,
   // [28] alert, [31:29] zero.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [emgrms_pkg::RSP_DAT_W-1:0]     rsp_tdata,
   // Configuration writes.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [emgrms_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [emgrms_pkg::CSR_DAT_W-1:0]     csr_data
);

   localparam int SW     = emgrms_pkg::SAMPLE_W;
   localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int FILL_W = $clog2(WINDOW_LEN + 1);
   localparam int SUM_W  = 2 * SW + SLOT_W;
   localparam int TERM_W = SUM_W + 2;
   localparam int PROD_W = 2 * SW;
   localparam int BIT_W  = $clog2(SW);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SUB,
      ST_ADD,
      ST_ROOT,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [SW-1:0]                     bias_ff, bias_in;
   logic [SW-1:0]                     thr_ff, thr_in;
   logic [emgrms_pkg::RUNS_W-1:0]     runs_ff, runs_in;

   logic [SW-1:0]                     raw_ff, raw_in;
   logic [SW-1:0]                     rect_ff, rect_in;
   logic [SW-1:0]                     rd_ff;
   logic [SLOT_W-1:0]                 slot_ff, slot_in;
   logic [FILL_W-1:0]                 fill_ff, fill_in;
   logic [SUM_W-1:0]                  sum_ff, sum_in;

   logic [TERM_W-1:0]                 sq_ff, sq_in;
   logic [TERM_W-1:0]                 t_ff, t_in;
   logic [TERM_W-1:0]                 wk_ff, wk_in;
   logic [SW-1:0]                     root_ff, root_in;
   logic [BIT_W-1:0]                  bit_ff, bit_in;

   logic [emgrms_pkg::RUN_W-1:0]      run_ff, run_in;
   logic                              alert_ff, alert_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [emgrms_pkg::RSP_DAT_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [SW-1:0]                     mem [WINDOW_LEN];

   logic                              full;
   logic [SW-1:0]                     mul_a;
   logic [PROD_W-1:0]                 prod;
   logic [TERM_W-1:0]                 cand;
   logic                              fits;
   logic                              over;
   logic [emgrms_pkg::RUN_W-1:0]      run_next;
   logic                              alert_next;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   assign full = (fill_ff == FILL_W'(WINDOW_LEN));

   // The one multiplier squares the departing sample, then the new one.
   assign mul_a = (state_ff == ST_SUB) ? rd_ff : rect_ff;
   assign prod  = PROD_W'(mul_a) * PROD_W'(mul_a);

   // Root step: (r + b)^2 * W = r^2*W + (r*W << (k+1)) + (W << 2k).
   assign cand = sq_ff + t_ff + wk_ff;
   assign fits = (cand <= TERM_W'(sum_ff));

   assign over     = (root_ff >= thr_ff);
   assign run_next = !over ? '0 : (run_ff == emgrms_pkg::RUN_MAX) ? run_ff
                                                                  : run_ff + 1'b1;
   assign alert_next = alert_ff
                     | (over && (run_next >= emgrms_pkg::RUN_W'(runs_ff)));

   always_comb begin
      state_in     = state_ff;
      bias_in      = bias_ff;
      thr_in       = thr_ff;
      runs_in      = runs_ff;
      raw_in       = raw_ff;
      rect_in      = rect_ff;
      slot_in      = slot_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      t_in         = t_ff;
      wk_in        = wk_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      run_in       = run_ff;
      alert_in     = alert_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         unique case (csr_index)
            emgrms_pkg::REG_BIAS_LEVEL:      bias_in = csr_data;
            emgrms_pkg::REG_ALERT_THRESHOLD: thr_in  = csr_data;
            emgrms_pkg::REG_RUNS_TO_ALERT:   runs_in = csr_data[emgrms_pkg::RUNS_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               raw_in   = req_tdata[SW-1:0];
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            rect_in  = (raw_ff >= bias_ff) ? raw_ff - bias_ff : bias_ff - raw_ff;
            state_in = ST_SUB;
         end
         ST_SUB: begin
            if (full) begin
               sum_in = sum_ff - SUM_W'(prod);
            end
            state_in = ST_ADD;
         end
         ST_ADD: begin
            sum_in  = sum_ff + SUM_W'(prod);
            slot_in = (slot_ff == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_ff + 1'b1;
            sq_in   = '0;
            t_in    = '0;
            wk_in   = TERM_W'(WINDOW_LEN) << (2 * (SW - 1));
            root_in = '0;
            bit_in  = BIT_W'(SW - 1);
            if (full) begin
               state_in = ST_ROOT;
            end else begin
               fill_in  = fill_ff + 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_ROOT: begin
            if (fits) begin
               sq_in            = cand;
               root_in[bit_ff]  = 1'b1;
               t_in             = (t_ff + (wk_ff << 1)) >> 1;
            end else begin
               t_in = t_ff >> 1;
            end
            wk_in  = wk_ff >> 2;
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               run_in       = run_next;
               alert_in     = alert_next;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, alert_next, run_next, root_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bias_ff      <= emgrms_pkg::BIAS_RESET;
         thr_ff       <= emgrms_pkg::THRESHOLD_RESET;
         runs_ff      <= emgrms_pkg::RUNS_RESET;
         slot_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         run_ff       <= '0;
         alert_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bias_ff      <= bias_in;
         thr_ff       <= thr_in;
         runs_ff      <= runs_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         run_ff       <= run_in;
         alert_ff     <= alert_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      raw_ff      <= raw_in;
      rect_ff     <= rect_in;
      sq_ff       <= sq_in;
      t_ff        <= t_in;
      wk_ff       <= wk_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Window memory: read the departing sample while the new one is rectified,
   // then overwrite that slot.
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD) begin
         rd_ff <= mem[slot_ff];
      end
      if (state_ff == ST_SUB) begin
         mem[slot_ff] <= rect_ff;
      end
   end

endmodule

/* src/emgrms_checker.sv */
// ----------------------------------------------------------------------------
// EMG window RMS alert checker
// Port-level assertions on the request and response streams, bound to the
// top level.
// ----------------------------------------------------------------------------
module emgrms_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [emgrms_pkg::RSP_DAT_W-1:0]  rsp_tdata
);

   logic seen_alert_ff, seen_alert_in;
   logic rsp_take;

   assign rsp_take      = rsp_tvalid && rsp_tready;
   assign seen_alert_in = seen_alert_ff
                        | (rsp_take && rsp_tdata[emgrms_pkg::RSP_ALERT_BIT]);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_alert_ff <= 1'b0;
      end else begin
         seen_alert_ff <= seen_alert_in;
      end
   end

   // A waiting response holds its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // One request at a time: an accepted request blocks the next for a while.
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready ##1 !req_tready)
      else $error("request accepted while busy");

   // Once the alert has been reported, every later response reports it.
   a_alert_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_take && seen_alert_ff |-> rsp_tdata[emgrms_pkg::RSP_ALERT_BIT])
      else $error("alert cleared without reset");

   // Unused upper bits of the response stay zero.
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[emgrms_pkg::RSP_DAT_W-1:emgrms_pkg::RSP_ALERT_BIT+1] == '0)
      else $error("response padding not zero");

endmodule

bind emg_window_rms_alert_top emgrms_checker u_emgrms_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* dv/emg_window_rms_alert_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EMG window RMS alert checker
// Watches the request, response and register write channels. It keeps its own
// copy of the sample window, square sum, run counter and alert latch, and it
// compares every response with the oldest predicted one.
// ----------------------------------------------------------------------------
module emg_window_rms_alert_checker
   import emgrms_pkg::*;
#(
   parameter int WINDOW_LEN = 128
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [REQ_DAT_W-1:0] req_tdata,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [RSP_DAT_W-1:0] rsp_tdata,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data,
   output int unsigned          mismatch_count,
   output int unsigned          pending_count
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [SAMPLE_W-1:0] level;
      logic [RUN_W-1:0]    run;
      logic                alert;
   } rms_result_type;

   logic [SAMPLE_W-1:0] bias_level;
   logic [SAMPLE_W-1:0] alert_threshold;
   logic [RUNS_W-1:0]   runs_to_alert;

   logic [SAMPLE_W-1:0] rect_window [WINDOW_LEN];
   int unsigned         write_slot;
   int unsigned         fill_count;
   longint unsigned     square_sum;
   logic [RUN_W-1:0]    run_length;
   logic                alert_latched;

   rms_result_type      rms_result_q [$];
   rms_result_type      expected;
   rms_result_type      actual;
   logic                pad_dirty;
   int unsigned         mismatches;

   function automatic logic [SAMPLE_W-1:0] floor_sqrt(input longint unsigned value);
      logic [SAMPLE_W-1:0] root;
      logic [SAMPLE_W-1:0] trial;
      longint unsigned     trial_sq;
      root = '0;
      for (int b = SAMPLE_W - 1; b >= 0; b--) begin
         trial    = root | (SAMPLE_W'(1) << b);
         trial_sq = trial;
         trial_sq = trial_sq * trial_sq;
         if (trial_sq <= value) begin
            root = trial;
         end
      end
      return root;
   endfunction

   // The window only yields a result once it is full, so the oldest slot is
   // always one that has been written before it is read back.
   task automatic take_sample(input logic [SAMPLE_W-1:0] raw);
      logic [SAMPLE_W-1:0] rect;
      longint unsigned     sq;
      rms_result_type      res;
      rect = (raw >= bias_level) ? raw - bias_level : bias_level - raw;
      if (fill_count >= WINDOW_LEN) begin
         sq = rect_window[write_slot];
         square_sum -= sq * sq;
      end
      sq = rect;
      square_sum += sq * sq;
      rect_window[write_slot] = rect;
      write_slot = (write_slot + 1) % WINDOW_LEN;
      if (fill_count < WINDOW_LEN) begin
         fill_count++;
      end else begin
         res.level = floor_sqrt(square_sum / WINDOW_LEN);
         if (res.level >= alert_threshold) begin
            if (run_length != RUN_MAX) begin
               run_length++;
            end
            if (run_length >= runs_to_alert) begin
               alert_latched = 1'b1;
            end
         end else begin
            run_length = '0;
         end
         res.run   = run_length;
         res.alert = alert_latched;
         rms_result_q.push_back(res);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         bias_level      = BIAS_RESET;
         alert_threshold = THRESHOLD_RESET;
         runs_to_alert   = RUNS_RESET;
         foreach (rect_window[i]) begin
            rect_window[i] = '0;
         end
         write_slot    = 0;
         fill_count    = 0;
         square_sum    = 0;
         run_length    = '0;
         alert_latched = 1'b0;
         rms_result_q.delete();
         mismatches = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_BIAS_LEVEL:      bias_level      = csr_data[SAMPLE_W-1:0];
               REG_ALERT_THRESHOLD: alert_threshold = csr_data[SAMPLE_W-1:0];
               REG_RUNS_TO_ALERT:   runs_to_alert   = csr_data[RUNS_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            actual.level = rsp_tdata[SAMPLE_W-1:0];
            actual.run   = rsp_tdata[RSP_RUN_LSB +: RUN_W];
            actual.alert = rsp_tdata[RSP_ALERT_BIT];
            pad_dirty    = |rsp_tdata[RSP_DAT_W-1:RSP_ALERT_BIT+1];
            if (rms_result_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("%0t: response with none expected: level %0d run %0d alert %0d",
                           $time, actual.level, actual.run, actual.alert);
               end
            end else begin
               expected = rms_result_q.pop_front();
               if (actual.level != expected.level || actual.run != expected.run ||
                   actual.alert != expected.alert || pad_dirty) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display({"%0t: response mismatch (expected/actual): ",
                               "level %0d/%0d run %0d/%0d alert %0d/%0d pad %0d"},
                              $time, expected.level, actual.level,
                              expected.run, actual.run,
                              expected.alert, actual.alert, pad_dirty);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            take_sample(req_tdata[SAMPLE_W-1:0]);
         end
      end
      mismatch_count <= mismatches;
      pending_count  <= rms_result_q.size();
   end

endmodule

/* dv/emg_window_rms_alert_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EMG window RMS alert testbench
// Drives converter samples through several register settings with random
// gaps and response stalls, including one long response hold-off, and leaves
// all prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module emg_window_rms_alert_top_tb;
   import emgrms_pkg::*;

   localparam int WINDOW_LEN     = 128;
   localparam int SETTLE_CYCLES  = 24;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_AFTER     = 200;
   localparam int HOLD_CYCLES    = 600;
   localparam int NUM_PHASES     = 6;
   localparam int MAX_GAP        = 17;
   localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;

   // Indexes outside the register map; writes to them must change nothing.
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_LOW  = 8'd3;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_HIGH = 8'hFF;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic [REQ_DAT_W-1:0] req_tdata  = '0;
   logic                 rsp_tready = 1'b0;
   logic                 csr_valid  = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CSR_DAT_W-1:0] csr_data   = '0;
   logic                 req_tready;
   logic                 rsp_tvalid;
   logic [RSP_DAT_W-1:0] rsp_tdata;
   logic                 csr_ready;
   int unsigned          mismatch_count;
   int unsigned          pending_count;

   logic [SAMPLE_W-1:0]  corner_samples [20];
   int                   send_calm;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   emg_window_rms_alert_top #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   emg_window_rms_alert_checker #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // Mostly samples near the bias, with a share of full-scale noise.
   function automatic logic [SAMPLE_W-1:0] draw_sample(input int center, input int amp,
                                                       input int noise_pct);
      int v;
      if ($urandom_range(0, 99) < noise_pct) begin
         if ($urandom_range(0, 3) == 0) begin
            return $urandom_range(0, 1) ? {SAMPLE_W{1'b1}} : {SAMPLE_W{1'b0}};
         end
         return SAMPLE_W'($urandom);
      end
      v = center + int'($urandom_range(0, 2 * amp)) - amp;
      if (v < 0) begin
         v = 0;
      end else if (v > SAMPLE_MAX) begin
         v = SAMPLE_MAX;
      end
      return SAMPLE_W'(v);
   endfunction

   // The valid line stays high when the next request follows without a gap.
   task automatic send_sample(input logic [SAMPLE_W-1:0] raw);
      int gap;
      if (send_calm > 0) begin
         gap = 0;
         send_calm--;
      end else begin
         gap = $urandom_range(0, MAX_GAP);
         if ($urandom_range(0, 29) == 0) begin
            send_calm = $urandom_range(20, 60);
         end
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DAT_W'(raw);
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // A request during window fill gives no response, so the block may still
   // be busy after the last response; wait out its latency as well.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : receiver
      int stall;
      int taken;
      int calm;
      taken = 0;
      calm  = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken == HOLD_AFTER) begin
            stall = HOLD_CYCLES;
         end else if (calm > 0) begin
            stall = 0;
            calm--;
         end else begin
            stall = $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 29) == 0) begin
               calm = $urandom_range(20, 60);
            end
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("end of test: mismatches");
      $finish;
   end

   initial begin : stimulus
      logic [SAMPLE_W-1:0] bias_pick;
      int center;
      int amp;
      int noise;
      int burst;
      int count;
      send_calm = 0;
      corner_samples = '{12'h000, 12'hFFF, 12'h800, 12'h7FF, 12'h801, 12'h001, 12'hFFE,
                         12'h555, 12'hAAA, 12'h0F0, 12'hF0F, 12'h3C3, 12'hC3C, 12'h124,
                         12'hEDB, 12'h400, 12'hBFF, 12'h000, 12'hFFF, 12'h800};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Corner samples under the reset settings; they only fill the window.
      foreach (corner_samples[i]) begin
         send_sample(corner_samples[i]);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p > 0) begin
            settle();
         end
         burst = 0;
         count = 260;
         case (p)
            0: begin
               center = BIAS_RESET;
               amp    = 300;
               noise  = 1;
            end
            1: begin
               // A full window of top codes reaches the largest level, which
               // equals the threshold and so counts as over.
               csr_write(REG_BIAS_LEVEL, '0);
               csr_write(REG_ALERT_THRESHOLD, 12'hFFF);
               csr_write(REG_RUNS_TO_ALERT, 12'h0FF);
               csr_write(REG_UNUSED_LOW, 12'h123);
               center = 0;
               amp    = SAMPLE_MAX;
               noise  = 20;
               burst  = 140;
            end
            2: begin
               // Every result is over, so the run climbs past 255 and latches.
               csr_write(REG_BIAS_LEVEL, 12'hFFF);
               csr_write(REG_ALERT_THRESHOLD, '0);
               csr_write(REG_RUNS_TO_ALERT, 12'hFFF);
               csr_write(REG_UNUSED_HIGH, 12'hFFF);
               center = SAMPLE_MAX;
               amp    = SAMPLE_MAX;
               noise  = 20;
               count  = 300;
            end
            3: begin
               bias_pick = SAMPLE_W'($urandom);
               csr_write(REG_BIAS_LEVEL, bias_pick);
               csr_write(REG_ALERT_THRESHOLD, CSR_DAT_W'($urandom_range(200, 1500)));
               csr_write(REG_RUNS_TO_ALERT, '0);
               center = bias_pick;
               amp    = $urandom_range(100, 2000);
               noise  = 5;
            end
            4: begin
               csr_write(REG_BIAS_LEVEL, BIAS_RESET);
               csr_write(REG_ALERT_THRESHOLD, CSR_DAT_W'($urandom_range(300, 1500)));
               csr_write(REG_RUNS_TO_ALERT, 12'h001);
               center = BIAS_RESET;
               amp    = $urandom_range(100, 2048);
               noise  = 5;
            end
            default: begin
               bias_pick = SAMPLE_W'($urandom);
               csr_write(REG_BIAS_LEVEL, bias_pick);
               csr_write(REG_ALERT_THRESHOLD, CSR_DAT_W'($urandom));
               csr_write(REG_RUNS_TO_ALERT, CSR_DAT_W'($urandom));
               center = bias_pick;
               amp    = $urandom_range(0, SAMPLE_MAX);
               noise  = 10;
            end
         endcase
         csr_valid <= 1'b0;
         for (int n = 0; n < count; n++) begin
            send_sample((n < burst) ? {SAMPLE_W{1'b1}} : draw_sample(center, amp, noise));
         end
      end

      settle();
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* emg_window_rms_alert_top.f */
src/emgrms_pkg.sv
src/emg_window_rms_alert_top.sv
src/emgrms_checker.sv
dv/emg_window_rms_alert_checker.sv
dv/emg_window_rms_alert_top_tb.sv
